FILE: src/tti_pkg.sv
package tti_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int CV_W    = 16;
    localparam int CP_W    = 14;
    localparam int VT_W    = 13;

    localparam int CV_BASE = 1000;
    localparam int CV_STEP = 500;
    localparam int CP_BASE = 4800;
    localparam int CP_STEP = 100;
    localparam int VT_BASE = 400;
    localparam int VT_STEP = 100;

    localparam int ADDR_W  = 16;
    localparam int RATIO_W = 18;
    localparam int FRAC_W  = 16;
    localparam int BLEND_W = 36;
    localparam int SUM_W   = 38;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [VALUE_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [ADDR_W-1:0]         lo_off;
        logic [ADDR_W-1:0]         hi_off;
        logic signed [RATIO_W-1:0] ratio;
    } t_axis;

    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] entry_value;
        t_axis                     a;
        t_axis                     b;
        t_axis                     c;
    } t_job;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

FILE: src/tti_axis.sv
module tti_axis import tti_pkg::*; #(
    parameter int W     = 16,
    parameter int BASE  = 1000,
    parameter int STEP  = 500,
    parameter int N     = 3,
    parameter int SCALE = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_x,
    output t_axis        o_axis
);

    localparam int IW  = $clog2(N);
    localparam int MW  = $clog2(STEP);
    localparam int R1  = (2 ** W) / STEP;
    localparam int R2  = (2 ** (FRAC_W + MW)) / STEP;
    localparam int R2W = FRAC_W + 1 + MW;
    localparam int P1W = 2 * W + 1;
    localparam int P2W = MW + R2W;
    localparam int N2W = FRAC_W + MW + 1;
    localparam int QW  = FRAC_W + 1;

    logic           n_ge, n_near;
    logic [W-1:0]   n_dp;
    logic [MW-1:0]  n_magn;
    logic [P1W-1:0] n_p1;
    logic           r_ge, r_near;
    logic [W-1:0]   r_dp;
    logic [MW-1:0]  r_magn;
    logic [P1W-1:0] r_p1;

    logic [W-1:0]   q_est;
    logic [W:0]     rem_w;
    logic [W-1:0]   n_q;
    logic [MW-1:0]  n_rem;
    logic           r2_ge, r2_near;
    logic [MW-1:0]  r2_magn;
    logic [W-1:0]   r_q;
    logic [MW-1:0]  r_rem;

    logic [IW-1:0]  n_lo, n_hi;
    logic           n_zero, n_neg;
    logic [MW-1:0]  n_mag;
    logic [P2W-1:0] n_p2;
    logic [IW-1:0]  r_lo, r_hi;
    logic           r_zero, r_neg;
    logic [MW-1:0]  r_mag;
    logic [P2W-1:0] r_p2;

    logic [QW-1:0]             q2_est, q2;
    logic [N2W-1:0]            rem2;
    logic signed [RATIO_W-1:0] rmag;
    t_axis                     n_axis;
    t_axis                     r_axis;

    always_comb begin
        n_ge   = int'(i_x) >= BASE;
        n_near = (int'(i_x) < BASE) && (int'(i_x) + STEP > BASE);
        n_dp   = W'(int'(i_x) - BASE);
        n_magn = MW'(BASE - int'(i_x));
        n_p1   = P1W'(n_dp) * P1W'(R1);
    end

    always_comb begin
        q_est = W'(r_p1 >> W);
        rem_w = (W+1)'(r_dp) - (W+1)'(q_est) * (W+1)'(STEP);
        if (rem_w >= (W+1)'(STEP)) begin
            n_q   = q_est + W'(1);
            n_rem = MW'(rem_w - (W+1)'(STEP));
        end else begin
            n_q   = q_est;
            n_rem = MW'(rem_w);
        end
    end

    always_comb begin
        n_lo   = '0;
        n_hi   = '0;
        n_zero = 1'b1;
        n_neg  = 1'b0;
        n_mag  = '0;
        if (r2_ge) begin
            if (int'(r_q) >= N - 1) begin
                n_lo = IW'(N - 1);
                n_hi = IW'(N - 1);
            end else begin
                n_lo   = IW'(r_q);
                n_hi   = IW'(int'(r_q) + 1);
                n_zero = 1'b0;
                n_mag  = r_rem;
            end
        end else if (r2_near) begin
            n_hi   = IW'(1);
            n_zero = 1'b0;
            n_neg  = 1'b1;
            n_mag  = r2_magn;
        end
        n_p2 = P2W'(n_mag) * P2W'(R2);
    end

    always_comb begin
        q2_est = QW'(r_p2 >> MW);
        rem2   = (N2W'(r_mag) << FRAC_W) - N2W'(q2_est) * N2W'(STEP);
        q2     = (rem2 >= N2W'(STEP)) ? q2_est + QW'(1) : q2_est;
        rmag   = $signed(RATIO_W'(q2));
        n_axis.lo_off = ADDR_W'(r_lo) * ADDR_W'(SCALE);
        n_axis.hi_off = ADDR_W'(r_hi) * ADDR_W'(SCALE);
        if (r_zero) begin
            n_axis.ratio = '0;
        end else if (r_neg) begin
            n_axis.ratio = -rmag;
        end else begin
            n_axis.ratio = rmag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ge    <= n_ge;
            r_near  <= n_near;
            r_dp    <= n_dp;
            r_magn  <= n_magn;
            r_p1    <= n_p1;
            r2_ge   <= r_ge;
            r2_near <= r_near;
            r2_magn <= r_magn;
            r_q     <= n_q;
            r_rem   <= n_rem;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_zero  <= n_zero;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_p2    <= n_p2;
            r_axis  <= n_axis;
        end
    end

    assign o_axis = r_axis;

endmodule

FILE: src/tti_front.sv
module tti_front import tti_pkg::*; #(
    parameter int FIRST  = 3,
    parameter int SECOND = 17,
    parameter int THIRD  = 14
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_kind,
    input  logic [INDEX_W-1:0]        i_entry_index,
    input  logic signed [VALUE_W-1:0] i_entry_value,
    input  logic [CV_W-1:0]           i_cv,
    input  logic [CP_W-1:0]           i_cp,
    input  logic [VT_W-1:0]           i_vt,
    output logic                      o_push,
    input  logic                      i_full,
    output t_job                      o_job
);

    localparam int STAGES = 4;

    logic                              en;
    logic [STAGES-1:0]                 r_vld;
    logic [STAGES-1:0]                 r_kind;
    logic [STAGES-1:0][INDEX_W-1:0]    r_idx;
    logic [STAGES-1:0][VALUE_W-1:0]    r_val;
    t_axis                             axis_a, axis_b, axis_c;

    assign en     = !r_vld[STAGES-1] || !i_full;
    assign o_full = !en;
    assign o_push = r_vld[STAGES-1] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STAGES-2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind <= {r_kind[STAGES-2:0], i_kind};
            r_idx  <= {r_idx[STAGES-2:0], i_entry_index};
            r_val  <= {r_val[STAGES-2:0], i_entry_value};
        end
    end

    tti_axis #(
        .W(CV_W), .BASE(CV_BASE), .STEP(CV_STEP), .N(FIRST), .SCALE(SECOND * THIRD)
    ) u_axis_a (
        .i_clk(i_clk), .i_en(en), .i_x(i_cv), .o_axis(axis_a)
    );

    tti_axis #(
        .W(CP_W), .BASE(CP_BASE), .STEP(CP_STEP), .N(SECOND), .SCALE(THIRD)
    ) u_axis_b (
        .i_clk(i_clk), .i_en(en), .i_x(i_cp), .o_axis(axis_b)
    );

    tti_axis #(
        .W(VT_W), .BASE(VT_BASE), .STEP(VT_STEP), .N(THIRD), .SCALE(1)
    ) u_axis_c (
        .i_clk(i_clk), .i_en(en), .i_x(i_vt), .o_axis(axis_c)
    );

    always_comb begin
        o_job.kind        = r_kind[STAGES-1];
        o_job.entry_index = r_idx[STAGES-1];
        o_job.entry_value = $signed(r_val[STAGES-1]);
        o_job.a           = axis_a;
        o_job.b           = axis_b;
        o_job.c           = axis_c;
    end

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> r_vld[0])
        else $error("Accepted transaction did not enter the front pipeline.");

endmodule

FILE: src/tti_queue.sv
module tti_queue import tti_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("Transaction pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("Transaction popped from an empty queue.");

endmodule

FILE: src/tti_back.sv
module tti_back import tti_pkg::*; #(
    parameter int DEPTH = 714
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_job                      i_job,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic signed [VALUE_W-1:0] o_interpolated
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = 4;
    localparam int DIF_W = BLEND_W + 1;
    localparam int PRD_W = DIF_W + RATIO_W;

    localparam logic [CNT_W-1:0] SEQ_READ_LAST = 4'd7;
    localparam logic [CNT_W-1:0] BL_P0         = 4'd2;
    localparam logic [CNT_W-1:0] BL_P1         = 4'd4;
    localparam logic [CNT_W-1:0] BL_P2         = 4'd6;
    localparam logic [CNT_W-1:0] BL_P3         = 4'd8;
    localparam logic [CNT_W-1:0] BL_S0         = 4'd9;
    localparam logic [CNT_W-1:0] BL_S1         = 4'd10;
    localparam logic [CNT_W-1:0] BL_OUT        = 4'd12;
    localparam logic [CNT_W-1:0] WR_F0         = 4'd3;
    localparam logic [CNT_W-1:0] WR_F1         = 4'd5;
    localparam logic [CNT_W-1:0] WR_F2         = 4'd7;
    localparam logic [CNT_W-1:0] WR_F3         = 4'd9;
    localparam logic [CNT_W-1:0] WR_S0         = 4'd10;
    localparam logic [CNT_W-1:0] WR_S1         = 4'd11;
    localparam logic [CNT_W-1:0] SEQ_LAST      = 4'd13;

    t_state                     r_state, n_state;
    logic                       start, we;
    logic [CNT_W-1:0]           r_cnt;
    t_job                       r_job;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out;

    logic signed [VALUE_W-1:0]  r_mem [DEPTH];
    logic signed [VALUE_W-1:0]  r_rd, r_hold;
    logic [ADDR_W-1:0]          a_off, b_off, c_off, raddr;

    logic signed [BLEND_W-1:0]  bl_a, bl_b;
    logic signed [RATIO_W-1:0]  bl_r;
    logic signed [DIF_W-1:0]    diff;
    logic signed [PRD_W-1:0]    n_bl_p, r_bl_p;
    logic signed [BLEND_W-1:0]  r_bl_a;
    logic signed [SUM_W-1:0]    y;
    logic [VALUE_W-1:0]         sat;
    logic signed [BLEND_W-1:0]  r_f [4];
    logic signed [BLEND_W-1:0]  r_s [2];

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        start   = 1'b0;
        we      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_job.kind == KIND_LOAD) begin
                        o_pop = 1'b1;
                        we    = int'(i_job.entry_index) < DEPTH;
                    end else if (!r_out_valid) begin
                        o_pop   = 1'b1;
                        start   = 1'b1;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (r_cnt == SEQ_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_cnt <= '0;
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == ST_RUN && r_cnt == SEQ_LAST) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        a_off = r_cnt[0] ? r_job.a.hi_off : r_job.a.lo_off;
        c_off = r_cnt[1] ? r_job.c.hi_off : r_job.c.lo_off;
        b_off = r_cnt[2] ? r_job.b.hi_off : r_job.b.lo_off;
        raddr = a_off + b_off + c_off;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[AW'(i_job.entry_index)] <= i_job.entry_value;
        end
        r_rd <= r_mem[AW'(raddr)];
    end

    always_comb begin
        case (r_cnt) inside
            BL_P0, BL_P1, BL_P2, BL_P3: begin
                bl_a = BLEND_W'(r_hold);
                bl_b = BLEND_W'(r_rd);
                bl_r = r_job.a.ratio;
            end
            BL_S0: begin
                bl_a = r_f[0];
                bl_b = r_f[2];
                bl_r = r_job.b.ratio;
            end
            BL_S1: begin
                bl_a = r_f[1];
                bl_b = r_f[3];
                bl_r = r_job.b.ratio;
            end
            BL_OUT: begin
                bl_a = r_s[0];
                bl_b = r_s[1];
                bl_r = r_job.c.ratio;
            end
            default: begin
                bl_a = '0;
                bl_b = '0;
                bl_r = '0;
            end
        endcase
        diff   = DIF_W'(bl_b) - DIF_W'(bl_a);
        n_bl_p = diff * bl_r;
    end

    always_comb begin
        y = SUM_W'(r_bl_a) + SUM_W'(r_bl_p >>> FRAC_W);
        if ((&y[SUM_W-1:VALUE_W-1]) || !(|y[SUM_W-1:VALUE_W-1])) begin
            sat = y[VALUE_W-1:0];
        end else if (y[SUM_W-1]) begin
            sat = SAT_MIN;
        end else begin
            sat = SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_job <= i_job;
        end
        r_bl_a <= bl_a;
        r_bl_p <= n_bl_p;
        if (r_cnt[0] && r_cnt <= SEQ_READ_LAST) begin
            r_hold <= r_rd;
        end
        if (r_state == ST_RUN) begin
            case (r_cnt)
                WR_F0:    r_f[0] <= y[BLEND_W-1:0];
                WR_F1:    r_f[1] <= y[BLEND_W-1:0];
                WR_F2:    r_f[2] <= y[BLEND_W-1:0];
                WR_F3:    r_f[3] <= y[BLEND_W-1:0];
                WR_S0:    r_s[0] <= y[BLEND_W-1:0];
                WR_S1:    r_s[1] <= y[BLEND_W-1:0];
                SEQ_LAST: r_out  <= $signed(sat);
                default: ;
            endcase
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_interpolated = r_out;

    a_no_pop_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !o_pop)
        else $error("Queue popped while a query is in progress.");

    a_result_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_RUN && r_cnt == SEQ_LAST))
        else $error("Result appeared outside the final blend step.");

    a_start_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && n_state == ST_RUN) |-> !r_out_valid)
        else $error("Query started while the result register was occupied.");

endmodule

FILE: src/trilinear_table_interpolation.sv
// Queries are processed one at a time, paced by the eight corner reads through the
// single read port of the coefficient table, the shared blend unit and the wait for
// the previous result to be taken; a load is written into the table while the back
// end is idle.
// The front pipeline and a four-entry queue keep accepting transactions meanwhile, until both are full.
// Reset clears all control state; table contents are undefined until loaded.
module trilinear_table_interpolation import tti_pkg::*; #(
    parameter int FIRST_AXIS_POINTS  = 3,
    parameter int SECOND_AXIS_POINTS = 17,
    parameter int THIRD_AXIS_POINTS  = 14
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_kind,
    input  logic [INDEX_W-1:0]        i_entry_index,
    input  logic signed [VALUE_W-1:0] i_entry_value,
    input  logic [CV_W-1:0]           i_cv_micro,
    input  logic [CP_W-1:0]           i_cp_units,
    input  logic [VT_W-1:0]           i_vtol_units,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] o_interpolated
);

    logic f_push, q_full, q_empty, q_pop;
    t_job job_in, job_out;

    tti_front #(
        .FIRST(FIRST_AXIS_POINTS),
        .SECOND(SECOND_AXIS_POINTS),
        .THIRD(THIRD_AXIS_POINTS)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .o_full(full),
        .i_kind(i_kind),
        .i_entry_index(i_entry_index),
        .i_entry_value(i_entry_value),
        .i_cv(i_cv_micro),
        .i_cp(i_cp_units),
        .i_vt(i_vtol_units),
        .o_push(f_push),
        .i_full(q_full),
        .o_job(job_in)
    );

    tti_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(f_push),
        .i_data(job_in),
        .o_full(q_full),
        .i_pop(q_pop),
        .o_data(job_out),
        .o_empty(q_empty)
    );

    tti_back #(
        .DEPTH(FIRST_AXIS_POINTS * SECOND_AXIS_POINTS * THIRD_AXIS_POINTS)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_job(job_out),
        .i_empty(q_empty),
        .o_pop(q_pop),
        .o_empty(empty),
        .i_pop(pop),
        .o_interpolated(o_interpolated)
    );

endmodule
